[sv/pal_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and constants of the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

  // List geometry
  localparam int CAPACITY = 128;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int POS_W    = 8;
  localparam int DATA_W   = 32;
  localparam int STAT_W   = 2;
  localparam int OCNT_W   = 8;
  localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  // Removed-value reduction: cells are ORed in groups, groups are registered
  localparam int GROUP    = 16;
  localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

  // Operation codes
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_BAD_POS = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_HOLD
  } state_t;

  // Per-cycle command broadcast to the row of cells
  typedef struct packed {
    logic              ins_en;
    logic              del_en;
    logic [IDX_W-1:0]  pos_idx;
    logic [DATA_W-1:0] value;
  } row_ctrl_t;

endpackage

[sv/pal_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_in_if / pal_out_if
// Valid/ready channels for list requests and results.
// ----------------------------------------------------------------------------
interface pal_in_if;
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic [pal_pkg::POS_W-1:0]      position;
  logic signed [pal_pkg::DATA_W-1:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

interface pal_out_if;
  logic                              valid;
  logic                              ready;
  logic [pal_pkg::STAT_W-1:0]        status;
  logic signed [pal_pkg::DATA_W-1:0] removed_value;
  logic [pal_pkg::OCNT_W-1:0]        entry_count;

  modport source (output valid, output status, output removed_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input removed_value, input entry_count,
                  output ready);
endinterface

[sv/pal_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_cell
// One list slot: holds an entry and shifts with its neighbors.
// ----------------------------------------------------------------------------
module pal_cell (
  input  logic                         clk,
  input  logic [pal_pkg::IDX_W-1:0]    idx,
  input  pal_pkg::row_ctrl_t           ctrl,
  input  logic [pal_pkg::DATA_W-1:0]   left_data,
  input  logic [pal_pkg::DATA_W-1:0]   right_data,
  output logic [pal_pkg::DATA_W-1:0]   data,
  output logic [pal_pkg::DATA_W-1:0]   tap
);

  logic [pal_pkg::DATA_W-1:0] data_r;
  logic [pal_pkg::DATA_W-1:0] data_nxt;
  logic                       at_pos;
  logic                       past_pos;

  assign at_pos   = (idx == ctrl.pos_idx);
  assign past_pos = (idx >= ctrl.pos_idx);

  // Take the new value at the slot, shift up behind it on insert,
  // shift down from the right neighbor on delete
  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins_en) begin
      if (at_pos) begin
        data_nxt = ctrl.value;
      end else if (past_pos) begin
        data_nxt = left_data;
      end
    end else if (ctrl.del_en && past_pos) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

  // Offer the entry being deleted to the reduction tree
  assign tap = (ctrl.del_en && at_pos) ? data_r : '0;

endmodule

[sv/pal_row.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_row
// Row of list cells plus a registered OR tree that picks the removed entry.
// ----------------------------------------------------------------------------
module pal_row (
  input  logic                         clk,
  input  pal_pkg::row_ctrl_t           ctrl,
  output logic [pal_pkg::DATA_W-1:0]   removed
);

  logic [pal_pkg::DATA_W-1:0] cell_data [pal_pkg::CAPACITY];
  logic [pal_pkg::DATA_W-1:0] cell_tap  [pal_pkg::CAPACITY];
  logic [pal_pkg::DATA_W-1:0] grp_r     [pal_pkg::NGROUP];
  logic [pal_pkg::DATA_W-1:0] grp_nxt   [pal_pkg::NGROUP];

  // Build the chain of cells
  for (genvar i = 0; i < pal_pkg::CAPACITY; i++) begin : g_cell
    logic [pal_pkg::DATA_W-1:0] left_d;
    logic [pal_pkg::DATA_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end

    if (i == pal_pkg::CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    pal_cell u_cell (
      .clk        (clk),
      .idx        (pal_pkg::IDX_W'(i)),
      .ctrl       (ctrl),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  // Reduce each group of taps; only the deleted slot drives nonzero
  for (genvar g = 0; g < pal_pkg::NGROUP; g++) begin : g_grp
    always_comb begin
      grp_nxt[g] = '0;
      for (int k = 0; k < pal_pkg::GROUP; k++) begin
        if (g * pal_pkg::GROUP + k < pal_pkg::CAPACITY) begin
          grp_nxt[g] = grp_nxt[g] | cell_tap[g * pal_pkg::GROUP + k];
        end
      end
    end

    always_ff @(posedge clk) begin
      grp_r[g] <= grp_nxt[g];
    end
  end

  // Combine the registered groups
  always_comb begin
    removed = '0;
    for (int g = 0; g < pal_pkg::NGROUP; g++) begin
      removed = removed | grp_r[g];
    end
  end

endmodule

[sv/positional_array_list.sv]
`timescale 1ns / 1ps
// A result is valid in ST_HOLD, after the request is accepted in ST_IDLE and
// the reduced removed entry is loaded into the result register in ST_REDUCE.
// One request is in flight at a time; a stalled result holds off the next request.
// All cells shift in parallel at the accept edge, so the list size does not
// affect timing. Reset empties the list and needs no clearing pass.
// ----------------------------------------------------------------------------
// positional_array_list
// Fixed-capacity ordered list with insert and delete at a one-based position.
// ----------------------------------------------------------------------------
module positional_array_list (
  input  logic           clk,
  input  logic           rst_n,
  pal_in_if.sink         in_ch,
  pal_out_if.source      out_ch
);

  pal_pkg::state_t             state_r;
  pal_pkg::state_t             state_nxt;
  logic [pal_pkg::CNT_W-1:0]   count_r;
  logic [pal_pkg::CNT_W-1:0]   count_nxt;
  pal_pkg::status_t            status_r;
  pal_pkg::status_t            status_nxt;
  logic [pal_pkg::STAT_W-1:0]  out_status_r;
  logic [pal_pkg::DATA_W-1:0]  out_removed_r;
  logic [pal_pkg::OCNT_W-1:0]  out_count_r;

  logic                        accept;
  logic                        load_out;
  logic [pal_pkg::CMP_W-1:0]   pos_ext;
  logic [pal_pkg::CMP_W-1:0]   cnt_ext;
  logic                        is_delete;
  logic                        bad_pos;
  logic                        full;
  pal_pkg::row_ctrl_t          ctrl;
  logic [pal_pkg::DATA_W-1:0]  removed;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pal_pkg::ST_IDLE:   if (in_ch.valid) state_nxt = pal_pkg::ST_REDUCE;
      pal_pkg::ST_REDUCE: state_nxt = pal_pkg::ST_HOLD;
      pal_pkg::ST_HOLD:   if (out_ch.ready) state_nxt = pal_pkg::ST_IDLE;
      default:            state_nxt = pal_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    load_out     = 1'b0;
    case (state_r)
      pal_pkg::ST_IDLE:   in_ch.ready  = 1'b1;
      pal_pkg::ST_REDUCE: load_out     = 1'b1;
      pal_pkg::ST_HOLD:   out_ch.valid = 1'b1;
      default:            in_ch.ready  = 1'b0;
    endcase
  end

  assign accept = in_ch.valid && in_ch.ready;

  // Check the request against the current count
  assign pos_ext   = pal_pkg::CMP_W'(in_ch.position);
  assign cnt_ext   = pal_pkg::CMP_W'(count_r);
  assign is_delete = (in_ch.operation == pal_pkg::OP_DELETE);
  assign full      = (count_r == pal_pkg::CNT_W'(pal_pkg::CAPACITY));

  always_comb begin
    if (is_delete) begin
      bad_pos = (pos_ext == '0) || (pos_ext > cnt_ext);
    end else begin
      bad_pos = (pos_ext == '0) || (pos_ext > cnt_ext + pal_pkg::CMP_W'(1));
    end
  end

  always_comb begin
    if (bad_pos) begin
      status_nxt = pal_pkg::STAT_BAD_POS;
    end else if (!is_delete && full) begin
      status_nxt = pal_pkg::STAT_FULL;
    end else begin
      status_nxt = pal_pkg::STAT_DONE;
    end
  end

  // Broadcast the shift command to the cells
  always_comb begin
    ctrl.ins_en  = accept && !is_delete && (status_nxt == pal_pkg::STAT_DONE);
    ctrl.del_en  = accept && is_delete && (status_nxt == pal_pkg::STAT_DONE);
    ctrl.pos_idx = pal_pkg::IDX_W'(pos_ext - pal_pkg::CMP_W'(1));
    ctrl.value   = in_ch.value;
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins_en) begin
      count_nxt = count_r + pal_pkg::CNT_W'(1);
    end else if (ctrl.del_en) begin
      count_nxt = count_r - pal_pkg::CNT_W'(1);
    end
  end

  pal_row u_row (
    .clk     (clk),
    .ctrl    (ctrl),
    .removed (removed)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pal_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Hold the status of the accepted request, then load the result register
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
    if (load_out) begin
      out_status_r  <= status_r;
      out_removed_r <= removed;
      out_count_r   <= pal_pkg::OCNT_W'(count_r);
    end
  end

  assign out_ch.status        = out_status_r;
  assign out_ch.removed_value = out_removed_r;
  assign out_ch.entry_count   = out_count_r;

endmodule
